// File: hw/rtl/met_pkg.sv
`timescale 1ns / 1ps

package met_pkg;

   // Default geometry of the unit.
   localparam int COORD_BITS_DEF = 12;
   localparam int FRAC_BITS_DEF  = 28;
   localparam int COUNT_BITS_DEF = 16;

   // Register file layout.
   localparam int LIMIT_W    = 16;
   localparam int EDGE_W     = 32;
   localparam int STEP_W     = 28;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 2;

   // The point c is first formed with this many fraction bits.
   localparam int WIDE_FRAC = 29;

   // Reset values of the registers.
   localparam logic [LIMIT_W-1:0] LIMIT_RST = 16'd1000;
   localparam logic [EDGE_W-1:0]  LEFT_RST  = 32'hE000_0000;
   localparam logic [EDGE_W-1:0]  TOP_RST   = 32'h1400_0000;
   localparam logic [STEP_W-1:0]  STEP_RST  = 28'h005_0000;

   // Register indexes on the configuration port.
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LIMIT = 2'd0,
      CSR_LEFT  = 2'd1,
      CSR_TOP   = 2'd2,
      CSR_STEP  = 2'd3
   } csr_index_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;     // capture the pixel coordinates
      logic c_mul;    // coordinate times pixel step
      logic c_sum;    // form c, clear the iteration registers
      logic z_sum;    // new z from the registered products
      logic z_mul;    // square and cross products of the new z
      logic publish;  // load the output register
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic escaped;  // the last computed z lies outside radius two
   } dp_status_type;

endpackage

// File: hw/rtl/met_datapath.sv
`timescale 1ns / 1ps

module met_datapath
   import met_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                     clock,
   input  dp_cmd_type               cmd,
   output dp_status_type            status,
   input  logic [COORD_BITS-1:0]    pixel_column,
   input  logic [COORD_BITS-1:0]    pixel_row,
   input  logic signed [EDGE_W-1:0] left_edge,
   input  logic signed [EDGE_W-1:0] top_edge,
   input  logic [STEP_W-1:0]        pixel_step,
   input  logic [COUNT_BITS-1:0]    final_count,
   input  logic                     final_in_set,
   output logic [COORD_BITS-1:0]    result_column,
   output logic [COORD_BITS-1:0]    result_row,
   output logic [COUNT_BITS-1:0]    escape_count,
   output logic                     in_set
);

   // z and c components carry four integer bits plus one guard bit.
   localparam int ZW     = FRAC_BITS + 5;
   localparam int SQW    = FRAC_BITS + 4;
   localparam int PW     = 2 * ZW;
   localparam int PROD_W = COORD_BITS + 1 + STEP_W;
   localparam int SW     = COORD_BITS + 33;
   localparam int EXW    = EDGE_W + ZW;
   localparam int UP     = (FRAC_BITS >= WIDE_FRAC) ? FRAC_BITS - WIDE_FRAC : 0;
   localparam int DN     = (FRAC_BITS >= WIDE_FRAC) ? 0 : WIDE_FRAC - FRAC_BITS;

   localparam logic signed [SW-1:0] C_LIM  = SW'(3) <<< WIDE_FRAC;
   localparam logic signed [ZW-1:0] TWO_Z  = ZW'(2) <<< FRAC_BITS;
   localparam logic [SQW:0]         FOUR_Q = (SQW + 1)'(4) << FRAC_BITS;

   logic [COORD_BITS-1:0]  col_ff, row_ff;
   logic [PROD_W-1:0]      prod_re_ff, prod_im_ff;
   logic signed [ZW-1:0]   a_ff, b_ff;
   logic signed [ZW-1:0]   zx_ff, zy_ff;
   logic                   range_ff;
   logic [SQW-1:0]         sqx_ff, sqy_ff;
   logic signed [ZW-1:0]   xy_ff;
   logic [COORD_BITS-1:0]  out_col_ff, out_row_ff;
   logic [COUNT_BITS-1:0]  out_count_ff;
   logic                   out_in_set_ff;

   logic [PROD_W-1:0]      prod_re_in, prod_im_in;
   logic signed [SW-1:0]   c_re_wide, c_im_wide;
   logic signed [ZW-1:0]   a_in, b_in;
   logic signed [ZW-1:0]   zx_in, zy_in;
   logic                   range_in;
   logic signed [PW-1:0]   pxx, pyy, pxy, pxy_shift;
   logic [SQW:0]           radius;

   // Clamp a component of c to +-3 and move it to the working fraction.
   function automatic logic signed [ZW-1:0] to_frac(input logic signed [SW-1:0] v);
      logic signed [SW-1:0]  c;
      logic signed [EXW-1:0] e;
      begin
         if (v > C_LIM) begin
            c = C_LIM;
         end else if (v < -C_LIM) begin
            c = -C_LIM;
         end else begin
            c = v;
         end
         e = (EXW'(c) <<< UP) >>> DN;
         return e[ZW-1:0];
      end
   endfunction

   // Coordinate terms (2*index + 1) * step.
   assign prod_re_in = PROD_W'({col_ff, 1'b1}) * PROD_W'(pixel_step);
   assign prod_im_in = PROD_W'({row_ff, 1'b1}) * PROD_W'(pixel_step);

   // Point c in the wide format, then clamped and converted.
   assign c_re_wide = (SW'(left_edge) <<< 1) + $signed(SW'(prod_re_ff));
   assign c_im_wide = (SW'(top_edge) <<< 1) - $signed(SW'(prod_im_ff));
   assign a_in      = to_frac(c_re_wide);
   assign b_in      = to_frac(c_im_wide);

   // New z from the products of the previous z.
   assign zx_in    = $signed(ZW'(sqx_ff)) - $signed(ZW'(sqy_ff)) + a_ff;
   assign zy_in    = xy_ff + b_ff;
   assign range_in = (zx_in > TWO_Z) || (zx_in < -TWO_Z) ||
                     (zy_in > TWO_Z) || (zy_in < -TWO_Z);

   // Full products of the new z, truncated toward minus infinity.
   assign pxx       = PW'(zx_ff) * PW'(zx_ff);
   assign pyy       = PW'(zy_ff) * PW'(zy_ff);
   assign pxy       = PW'(zx_ff) * PW'(zy_ff);
   assign pxy_shift = pxy >>> (FRAC_BITS - 1);

   // Escape test on the component range and the squared magnitude of the last z.
   assign radius         = {1'b0, sqx_ff} + {1'b0, sqy_ff};
   assign status.escaped = range_ff || (radius > FOUR_Q);

   // Datapath registers.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         col_ff <= pixel_column;
         row_ff <= pixel_row;
      end
      if (cmd.c_mul) begin
         prod_re_ff <= prod_re_in;
         prod_im_ff <= prod_im_in;
      end
      if (cmd.c_sum) begin
         a_ff     <= a_in;
         b_ff     <= b_in;
         range_ff <= 1'b0;
         sqx_ff   <= '0;
         sqy_ff   <= '0;
         xy_ff    <= '0;
      end
      if (cmd.z_sum) begin
         zx_ff    <= zx_in;
         zy_ff    <= zy_in;
         range_ff <= range_in;
      end
      if (cmd.z_mul) begin
         sqx_ff <= pxx[FRAC_BITS+SQW-1:FRAC_BITS];
         sqy_ff <= pyy[FRAC_BITS+SQW-1:FRAC_BITS];
         xy_ff  <= pxy_shift[ZW-1:0];
      end
      if (cmd.publish) begin
         out_col_ff    <= col_ff;
         out_row_ff    <= row_ff;
         out_count_ff  <= final_count;
         out_in_set_ff <= final_in_set;
      end
   end

   assign result_column = out_col_ff;
   assign result_row    = out_row_ff;
   assign escape_count  = out_count_ff;
   assign in_set        = out_in_set_ff;

endmodule

// File: hw/rtl/met_controller.sv
`timescale 1ns / 1ps

module met_controller
   import met_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [COUNT_BITS-1:0] limit,
   input  dp_status_type         status,
   output dp_cmd_type            cmd,
   output logic [COUNT_BITS-1:0] final_count,
   output logic                  final_in_set
);

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CMUL   = 6'b000010,
      ST_CSUM   = 6'b000100,
      ST_SUM    = 6'b001000,
      ST_MUL    = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   state_type             state_ff, state_in;
   logic [COUNT_BITS-1:0] iter_ff, iter_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  in_set_ff, in_set_in;
   logic                  valid_ff, valid_in;
   logic                  out_free;

   // The output register can take a result when empty or being emptied.
   assign out_free = !valid_ff || rsp_tready;

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      iter_in   = iter_ff;
      count_in  = count_ff;
      in_set_in = in_set_ff;
      valid_in  = valid_ff && !rsp_tready;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_CMUL;
            end
         end
         ST_CMUL: begin
            cmd.c_mul = 1'b1;
            state_in  = ST_CSUM;
         end
         ST_CSUM: begin
            cmd.c_sum = 1'b1;
            iter_in   = '0;
            state_in  = ST_SUM;
         end
         ST_SUM: begin
            // Escape of the previous iteration wins over the limit.
            if (status.escaped) begin
               count_in  = iter_ff - COUNT_BITS'(1);
               in_set_in = 1'b0;
               state_in  = ST_FINISH;
            end else if (iter_ff == limit) begin
               count_in  = iter_ff;
               in_set_in = 1'b1;
               state_in  = ST_FINISH;
            end else begin
               cmd.z_sum = 1'b1;
               iter_in   = iter_ff + COUNT_BITS'(1);
               state_in  = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd.z_mul = 1'b1;
            state_in  = ST_SUM;
         end
         ST_FINISH: begin
            if (out_free) begin
               cmd.publish = 1'b1;
               valid_in    = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff   <= iter_in;
      count_ff  <= count_in;
      in_set_ff <= in_set_in;
   end

   assign req_tready   = (state_ff == ST_IDLE);
   assign rsp_tvalid   = valid_ff;
   assign final_count  = count_ff;
   assign final_in_set = in_set_ff;

endmodule

// File: hw/rtl/mandelbrot_escape_time_unit.sv
`timescale 1ns / 1ps

// Channel  | Ports         | Contents
// ---------+---------------+------------------------------------------------
// request  | req_t*        | tdata: pixel_column, pixel_row
// response | rsp_t*        | tdata: result_column, result_row, escape_count;
//          |               | tuser: in_set
// config   | csr_*         | write only: limit, left edge, top edge, step
//
// One pixel is in progress at a time: the next is accepted only after the result
// of the last one has been loaded into the output register.
// Each iteration in the multiplier loop first adds, then squares. Reset is
// synchronous and restores the register defaults.
// A finished result waits in the output register while a new pixel is taken;
// the next result is held back until that one has been taken.

module mandelbrot_escape_time_unit
   import met_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int FRAC_BITS  = FRAC_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((2 * COORD_BITS + COUNT_BITS + 7) / 8) * 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_W-1:0]      req_tdata,   // pixel_column, pixel_row
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_W-1:0]      rsp_tdata,   // result_column, result_row, escape_count
   output logic                  rsp_tuser,   // in_set
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   logic [LIMIT_W-1:0]         limit_ff;
   logic signed [EDGE_W-1:0]   left_ff, top_ff;
   logic [STEP_W-1:0]          step_ff;
   logic [LIMIT_W+COUNT_BITS-1:0] limit_ext;
   logic [COUNT_BITS-1:0]      limit;

   dp_cmd_type                 cmd;
   dp_status_type              status;
   logic [COUNT_BITS-1:0]      final_count;
   logic                       final_in_set;
   logic [COORD_BITS-1:0]      result_column, result_row;
   logic [COUNT_BITS-1:0]      escape_count;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RST;
         left_ff  <= LEFT_RST;
         top_ff   <= TOP_RST;
         step_ff  <= STEP_RST;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_LIMIT: limit_ff <= csr_wdata[LIMIT_W-1:0];
            CSR_LEFT:  left_ff  <= csr_wdata[EDGE_W-1:0];
            CSR_TOP:   top_ff   <= csr_wdata[EDGE_W-1:0];
            CSR_STEP:  step_ff  <= csr_wdata[STEP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Only the low counter bits of the limit take part.
   assign limit_ext = {{COUNT_BITS{1'b0}}, limit_ff};
   assign limit     = limit_ext[COUNT_BITS-1:0];

   met_controller #(
      .COUNT_BITS(COUNT_BITS)
   ) u_controller (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .limit       (limit),
      .status      (status),
      .cmd         (cmd),
      .final_count (final_count),
      .final_in_set(final_in_set)
   );

   met_datapath #(
      .COORD_BITS(COORD_BITS),
      .FRAC_BITS (FRAC_BITS),
      .COUNT_BITS(COUNT_BITS)
   ) u_datapath (
      .clock        (clock),
      .cmd          (cmd),
      .status       (status),
      .pixel_column (req_tdata[COORD_BITS-1:0]),
      .pixel_row    (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .left_edge    (left_ff),
      .top_edge     (top_ff),
      .pixel_step   (step_ff),
      .final_count  (final_count),
      .final_in_set (final_in_set),
      .result_column(result_column),
      .result_row   (result_row),
      .escape_count (escape_count),
      .in_set       (rsp_tuser)
   );

   // Pack the response, first field in the low bits, zero filled.
   assign rsp_tdata = RSP_W'({escape_count, result_row, result_column});

endmodule

// File: hw/rtl/met_checker.sv
`timescale 1ns / 1ps

module met_checker
   import met_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   localparam int RSP_W = ((2 * COORD_BITS + COUNT_BITS + 7) / 8) * 8
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_W-1:0]      rsp_tdata,
   input logic                  rsp_tuser
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // One pixel at a time: no request is taken right after an acceptance.
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready ##1 !req_tready)
      else $error("request taken while a pixel is in progress");

   // A response never appears in the cycle after a request is taken.
   a_no_instant_rsp: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !$rose(rsp_tvalid))
      else $error("response appeared too early");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

bind mandelbrot_escape_time_unit met_checker #(
   .COORD_BITS(COORD_BITS),
   .COUNT_BITS(COUNT_BITS)
) u_met_checker (.*);
